// ===== rtl/core/csrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrg_pkg: shared types and constants of the CSR graph store
// Request and response layouts, request and status codes, register indexes.
// ----------------------------------------------------------------------------
package csrg_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 4096;

    localparam int VCOUNT_W   = 11;
    localparam int BUDGET_W   = 13;
    localparam int DEG_W      = 13;
    localparam int VTX_W      = 10;
    localparam int WGT_W      = 32;
    localparam int SLOT_W     = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_BUDGET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS      = 2'd2;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_LOOKUP = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SLOT  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef struct packed {
        req_kind_t                 req_type;
        logic [VTX_W-1:0]          vertex;
        logic [VTX_W-1:0]          neighbor;
        logic signed [WGT_W-1:0]   edge_weight;
        logic [SLOT_W-1:0]         slot;
        logic [DEG_W-1:0]          degree_in;
    } csrg_req_t;

    typedef struct packed {
        status_t                   status;
        logic [DEG_W-1:0]          degree_out;
        logic signed [WGT_W-1:0]   weight_out;
    } csrg_rsp_t;

    typedef struct packed {
        logic [DEG_W-1:0] start;
        logic [DEG_W-1:0] degree;
    } vtx_entry_t;

endpackage

// ===== rtl/core/csr_graph_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_graph_store: compressed-sparse-row graph store
// Requests transfer on the in channel, one response per request transfers on
// the out channel; both use valid and ready. Registers are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. A request is
// taken only while in_ready is high; one request is in work at a time.
// Degree loads, inserts and queries pass through the execute and done
// states; a request for a vertex out of range skips the execute state.
// A weight lookup walks the source list through the edge memory read port,
// one entry per cycle, until an entry matches or no entry is left. The next
// request can transfer in the cycle after the response is loaded into the
// output register.
// After reset the vertex table is cleared one entry per cycle; in_ready stays
// low during this pass. Edge memory contents are not cleared and read as
// undefined until written.
// When the receiver stalls, the response is held in the output register and
// the next finished response waits in the sequencer until it is taken.
// ----------------------------------------------------------------------------
module csr_graph_store #(
    parameter int MAX_VERTICES = csrg_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = csrg_pkg::DEF_MAX_EDGES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [csrg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csrg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  csrg_pkg::csrg_req_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output csrg_pkg::csrg_rsp_t                 out_data
);
    import csrg_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [VCOUNT_W-1:0]   vcount_reg;
    logic [BUDGET_W-1:0]   budget_reg;
    logic                  wen_reg;
    logic [DEG_W-1:0]      running_reg, running_next;
    logic [VW-1:0]         clr_idx_reg;
    logic [DEG_W-1:0]      idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic                  out_valid_reg;
    csrg_req_t             req_reg;
    csrg_rsp_t             res_reg, res_next;
    csrg_rsp_t             out_reg;

    logic [VCOUNT_W-1:0]   vlimit;
    logic [BUDGET_W-1:0]   blimit;
    logic                  accept;
    logic                  in_range;
    logic                  clear_done;
    logic                  out_load;
    logic [DEG_W-1:0]      add_a;
    logic [DEG_W-1:0]      add_b;
    logic [DEG_W:0]        sum;
    logic                  edge_ok;
    logic                  over_budget;
    logic                  slot_ok;
    logic                  scan_issue;
    logic                  hit;

    vtx_entry_t            vtx_rd;
    vtx_entry_t            vtx_wdata;
    logic                  vtx_we;
    logic [VW-1:0]         vtx_waddr;
    logic                  edge_we;
    logic                  edge_re;
    logic [VTX_W-1:0]      tgt_rd;
    logic signed [WGT_W-1:0] wgt_rd;

    assign vlimit = (32'(vcount_reg) < MAX_VERTICES) ? vcount_reg : VCOUNT_W'(MAX_VERTICES);
    assign blimit = (32'(budget_reg) < MAX_EDGES) ? budget_reg : BUDGET_W'(MAX_EDGES);

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign in_range   = {1'b0, in_data.vertex} < vlimit;
    assign clear_done = (clr_idx_reg == VW'(MAX_VERTICES - 1));
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Shared adder: running sum for loads, list address for inserts and scans.
    always_comb
    begin
        add_a = vtx_rd.start;
        add_b = {1'b0, req_reg.slot};
        if (state_reg == S_SCAN)
        begin
            add_b = idx_reg;
        end
        else if (req_reg.req_type == REQ_LOAD)
        begin
            add_a = running_reg;
            add_b = req_reg.degree_in;
        end
    end

    assign sum         = {1'b0, add_a} + {1'b0, add_b};
    assign edge_ok     = 32'(sum) < MAX_EDGES;
    assign over_budget = sum > {1'b0, blimit};
    assign slot_ok     = {1'b0, req_reg.slot} < vtx_rd.degree;
    assign scan_issue  = (idx_reg < vtx_rd.degree) && edge_ok;
    assign hit         = pend_reg && (tgt_rd == req_reg.neighbor);

    assign vtx_we    = (state_reg == S_CLEAR) ||
                       ((state_reg == S_EXEC) && (req_reg.req_type == REQ_LOAD) && !over_budget);
    assign vtx_waddr = (state_reg == S_CLEAR) ? clr_idx_reg : VW'(req_reg.vertex);
    assign vtx_wdata = (state_reg == S_CLEAR) ? vtx_entry_t'('0) :
                       vtx_entry_t'{start: running_reg, degree: req_reg.degree_in};

    assign edge_we = (state_reg == S_EXEC) && (req_reg.req_type == REQ_INSERT) &&
                     slot_ok && edge_ok;
    assign edge_re = (state_reg == S_SCAN) && !hit && scan_issue;

    csrg_vertex_table #(
        .DEPTH  (MAX_VERTICES),
        .ADDR_W (VW)
    ) u_vertex_table (
        .clk   (clk),
        .we    (vtx_we),
        .waddr (vtx_waddr),
        .wdata (vtx_wdata),
        .re    (accept),
        .raddr (VW'(in_data.vertex)),
        .rdata (vtx_rd)
    );

    csrg_edge_store #(
        .DEPTH  (MAX_EDGES),
        .ADDR_W (EW)
    ) u_edge_store (
        .clk       (clk),
        .tgt_we    (edge_we),
        .wgt_we    (edge_we && wen_reg),
        .addr      (EW'(sum)),
        .tgt_wdata (req_reg.neighbor),
        .wgt_wdata (req_reg.edge_weight),
        .re        (edge_re),
        .tgt_rdata (tgt_rd),
        .wgt_rdata (wgt_rd)
    );

    always_comb
    begin
        state_next   = state_reg;
        running_next = running_reg;
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        res_next     = res_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '{status: ST_OK, degree_out: '0, weight_out: '0};
                    if (in_range)
                    begin
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        res_next.status = ST_RANGE;
                        state_next      = S_DONE;
                    end
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (req_reg.req_type)
                    REQ_LOAD:
                    begin
                        if (over_budget)
                        begin
                            res_next.status = ST_MISS;
                        end
                        else
                        begin
                            running_next = sum[DEG_W-1:0];
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (!slot_ok)
                        begin
                            res_next.status = ST_SLOT;
                        end
                    end
                    REQ_QUERY:
                    begin
                        res_next.degree_out = vtx_rd.degree;
                    end
                    default:
                    begin
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_next.weight_out = wen_reg ? wgt_rd : '0;
                    state_next          = S_DONE;
                end
                else if (scan_issue)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    res_next.status = ST_MISS;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            vcount_reg    <= VCOUNT_W'(1024);
            budget_reg    <= BUDGET_W'(4096);
            wen_reg       <= 1'b0;
            running_reg   <= '0;
            clr_idx_reg   <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_VERTEX_COUNT: vcount_reg <= cfg_data[VCOUNT_W-1:0];
                    CFG_EDGE_BUDGET:  budget_reg <= cfg_data[BUDGET_W-1:0];
                    CFG_WEIGHTS:      wen_reg    <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            req_reg <= in_data;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/csrg_vertex_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrg_vertex_table: per-vertex start offset and degree memory
// One write port and one registered read port with a read enable.
// ----------------------------------------------------------------------------
module csrg_vertex_table #(
    parameter int DEPTH  = csrg_pkg::DEF_MAX_VERTICES,
    parameter int ADDR_W = $clog2(csrg_pkg::DEF_MAX_VERTICES)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  csrg_pkg::vtx_entry_t wdata,
    input  logic                 re,
    input  logic [ADDR_W-1:0]    raddr,
    output csrg_pkg::vtx_entry_t rdata
);
    import csrg_pkg::*;

    vtx_entry_t mem [DEPTH];
    vtx_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/csrg_edge_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrg_edge_store: shared edge target and weight memories
// Both memories share one address; reads are registered and enabled.
// ----------------------------------------------------------------------------
module csrg_edge_store #(
    parameter int DEPTH  = csrg_pkg::DEF_MAX_EDGES,
    parameter int ADDR_W = $clog2(csrg_pkg::DEF_MAX_EDGES)
) (
    input  logic                                clk,
    input  logic                                tgt_we,
    input  logic                                wgt_we,
    input  logic [ADDR_W-1:0]                   addr,
    input  logic [csrg_pkg::VTX_W-1:0]          tgt_wdata,
    input  logic signed [csrg_pkg::WGT_W-1:0]   wgt_wdata,
    input  logic                                re,
    output logic [csrg_pkg::VTX_W-1:0]          tgt_rdata,
    output logic signed [csrg_pkg::WGT_W-1:0]   wgt_rdata
);
    import csrg_pkg::*;

    logic [VTX_W-1:0]        tgt_mem [DEPTH];
    logic signed [WGT_W-1:0] wgt_mem [DEPTH];
    logic [VTX_W-1:0]        tgt_rdata_reg;
    logic signed [WGT_W-1:0] wgt_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[addr] <= tgt_wdata;
        end
        if (wgt_we)
        begin
            wgt_mem[addr] <= wgt_wdata;
        end
        if (re)
        begin
            tgt_rdata_reg <= tgt_mem[addr];
            wgt_rdata_reg <= wgt_mem[addr];
        end
    end

    assign tgt_rdata = tgt_rdata_reg;
    assign wgt_rdata = wgt_rdata_reg;

endmodule
